// File: rtl/core/ict_pkg.sv
// Package for the integer complexity table: widths, limits and the
// constant table of largest products reachable from k ones. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ict_pkg;
    localparam int ADDR_W = 16;
    localparam int VAL_W = 7;
    localparam int K_W = 7;
    localparam int PROD_W = 43;
    localparam int TAB_N = 128;
    localparam logic [VAL_W-1:0] VALUE_CAP = 7'd127;
    localparam logic [PROD_W-1:0] PROD_CAP = 43'h100_0000_0000;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [VAL_W-1:0] t_val;
    typedef logic [PROD_W-1:0] t_prod;
    typedef t_prod t_prod_tab [TAB_N];

    function automatic t_prod_tab build_prod_tab();
        t_prod_tab tab;
        logic [63:0] r;
        int kk;
        for (int k = 0; k < TAB_N; k++) begin
            r = 64'd1;
            kk = k;
            while (kk >= 5 || kk == 3) begin
                r = r * 64'd3;
                if (r > {21'd0, PROD_CAP}) begin
                    r = {21'd0, PROD_CAP};
                end
                kk = kk - 3;
            end
            r = r << (kk / 2);
            tab[k] = r[PROD_W-1:0];
        end
        return tab;
    endfunction

    localparam t_prod_tab MAX_PROD_TAB = build_prod_tab();

    function automatic t_val sat_add(input t_val a, input t_val b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, VALUE_CAP}) ? VALUE_CAP : s[VAL_W-1:0];
    endfunction
endpackage
`default_nettype wire

// File: rtl/core/ict_if.sv
// Handshake interfaces for the query and result channels.
// Depends on ict_pkg for the field types.
`timescale 1ns / 1ps
`default_nettype none
interface ict_query_if import ict_pkg::*; ();
    logic valid;
    logic ready;
    t_addr query_index;
    modport source (output valid, output query_index, input ready);
    modport sink (input valid, input query_index, output ready);
endinterface

interface ict_result_if import ict_pkg::*; ();
    logic valid;
    logic ready;
    t_val complexity;
    logic out_of_range;
    modport source (output valid, output complexity, output out_of_range, input ready);
    modport sink (input valid, input complexity, input out_of_range, output ready);
endinterface
`default_nettype wire

// File: rtl/core/integer_complexity_table_top.sv
// Integer complexity table: a 65536 x 7 memory extended in order on demand.
// A rejected request (index 0 or above the limit) goes straight to the result register,
// an already final index is read from memory first; one request is handled at a time.
// Extending one index reads entries n-1 and n (S_RD1-S_RD3), searches the bound (S_BND),
// tries sum terms (S_SA-S_SC) and pushes products (S_PA-S_PC), all through one read port.
// After reset a clearing pass fills the table; depends on ict_pkg, ict_if.
`timescale 1ns / 1ps
`default_nettype none
module integer_complexity_table_top import ict_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire t_addr     i_cfg_wdata,
    ict_query_if.sink      i_query,
    ict_result_if.source   o_result
);
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD1  = 4'd2;
    localparam logic [3:0] S_RD2  = 4'd3;
    localparam logic [3:0] S_RD3  = 4'd4;
    localparam logic [3:0] S_BND  = 4'd5;
    localparam logic [3:0] S_SA   = 4'd6;
    localparam logic [3:0] S_SB   = 4'd7;
    localparam logic [3:0] S_SC   = 4'd8;
    localparam logic [3:0] S_WRN  = 4'd9;
    localparam logic [3:0] S_PA   = 4'd10;
    localparam logic [3:0] S_PB   = 4'd11;
    localparam logic [3:0] S_PC   = 4'd12;
    localparam logic [3:0] S_NEXT = 4'd13;
    localparam logic [3:0] S_RDQ  = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    t_val mem [2**ADDR_W];

    logic [3:0] r_state, n_state;
    t_addr r_clr, n_clr;
    t_addr r_limit;
    t_addr r_fin, n_fin;
    t_addr r_q, n_q;
    t_addr r_n, n_n;
    t_addr r_m, n_m;
    logic [ADDR_W:0] r_mn, n_mn;
    logic [ADDR_W:0] r_bound, n_bound;
    logic [K_W-2:0] r_k, n_k;
    t_val r_prev, n_prev;
    t_val r_cur, n_cur;
    t_val r_a, n_a;
    logic r_use_mem, n_use_mem;
    logic r_rej, n_rej;
    logic r_ov, n_ov;
    t_val r_ocpx, n_ocpx;
    logic r_ooor, n_ooor;
    t_val r_rd_data;

    logic w_rd_en, w_wr_en;
    t_addr w_rd_addr, w_wr_addr;
    t_val w_wr_data;
    t_val w_sum;
    t_prod w_pk, w_pr;
    logic [PROD_W:0] w_psum;
    logic [K_W-1:0] w_rest;

    assign w_pk = MAX_PROD_TAB[{1'b0, r_k}];
    assign w_rest = r_prev - {1'b0, r_k};
    assign w_pr = MAX_PROD_TAB[w_rest];
    assign w_psum = {1'b0, w_pk} + {1'b0, w_pr};

    assign i_query.ready = (r_state == S_IDLE);
    assign o_result.valid = r_ov;
    assign o_result.complexity = r_ocpx;
    assign o_result.out_of_range = r_ooor;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        n_fin = r_fin;
        n_q = r_q;
        n_n = r_n;
        n_m = r_m;
        n_mn = r_mn;
        n_bound = r_bound;
        n_k = r_k;
        n_prev = r_prev;
        n_cur = r_cur;
        n_a = r_a;
        n_use_mem = r_use_mem;
        n_rej = r_rej;
        n_ov = r_ov && !o_result.ready;
        n_ocpx = r_ocpx;
        n_ooor = r_ooor;
        w_rd_en = 1'b0;
        w_rd_addr = r_n;
        w_wr_en = 1'b0;
        w_wr_addr = r_n;
        w_wr_data = r_cur;
        w_sum = sat_add(r_a, r_rd_data);
        unique case (r_state)
            S_CLR: begin
                w_wr_en = 1'b1;
                w_wr_addr = r_clr;
                w_wr_data = (r_clr == t_addr'(1)) ? t_val'(1) : VALUE_CAP;
                n_clr = r_clr + t_addr'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_query.valid) begin
                    n_q = i_query.query_index;
                    if (i_query.query_index == '0 || i_query.query_index > r_limit) begin
                        n_use_mem = 1'b0;
                        n_rej = 1'b1;
                        n_state = S_OUT;
                    end else if (i_query.query_index <= r_fin) begin
                        n_state = S_RDQ;
                    end else begin
                        n_n = r_fin + t_addr'(1);
                        n_state = S_RD1;
                    end
                end
            end
            S_RD1: begin
                w_rd_en = 1'b1;
                w_rd_addr = r_n - t_addr'(1);
                n_state = S_RD2;
            end
            S_RD2: begin
                w_rd_en = 1'b1;
                w_rd_addr = r_n;
                n_prev = r_rd_data;
                n_state = S_RD3;
            end
            S_RD3: begin
                w_sum = sat_add(r_prev, t_val'(1));
                n_cur = (w_sum < r_rd_data) ? w_sum : r_rd_data;
                n_k = r_prev[VAL_W-1:1];
                n_state = S_BND;
            end
            S_BND: begin
                if (r_k != '0 && w_psum < {{(PROD_W-ADDR_W+1){1'b0}}, r_n}) begin
                    n_k = r_k - 1'b1;
                end else begin
                    n_bound = (w_pk > t_prod'(2**ADDR_W)) ? (ADDR_W+1)'(2**ADDR_W)
                                                          : w_pk[ADDR_W:0];
                    n_m = t_addr'(6);
                    n_state = S_SA;
                end
            end
            S_SA: begin
                if ({1'b0, r_m} <= r_bound && r_m < r_n) begin
                    w_rd_en = 1'b1;
                    w_rd_addr = r_m;
                    n_state = S_SB;
                end else begin
                    n_state = S_WRN;
                end
            end
            S_SB: begin
                n_a = r_rd_data;
                w_rd_en = 1'b1;
                w_rd_addr = r_n - r_m;
                n_state = S_SC;
            end
            S_SC: begin
                if (w_sum < r_cur) begin
                    n_cur = w_sum;
                end
                n_m = r_m + t_addr'(1);
                n_state = S_SA;
            end
            S_WRN: begin
                w_wr_en = 1'b1;
                n_m = t_addr'(2);
                n_mn = {r_n, 1'b0};
                n_state = S_PA;
            end
            S_PA: begin
                if (r_m <= r_n && !r_mn[ADDR_W]) begin
                    w_rd_en = 1'b1;
                    w_rd_addr = r_m;
                    n_state = S_PB;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_PB: begin
                n_a = r_rd_data;
                w_rd_en = 1'b1;
                w_rd_addr = r_mn[ADDR_W-1:0];
                n_state = S_PC;
            end
            S_PC: begin
                w_sum = sat_add(r_a, r_cur);
                w_wr_addr = r_mn[ADDR_W-1:0];
                w_wr_data = w_sum;
                w_wr_en = (w_sum < r_rd_data);
                n_m = r_m + t_addr'(1);
                n_mn = r_mn + {1'b0, r_n};
                n_state = S_PA;
            end
            S_NEXT: begin
                n_fin = r_n;
                if (r_n == r_q) begin
                    n_state = S_RDQ;
                end else begin
                    n_n = r_n + t_addr'(1);
                    n_state = S_RD1;
                end
            end
            S_RDQ: begin
                w_rd_en = 1'b1;
                w_rd_addr = r_q;
                n_use_mem = 1'b1;
                n_rej = 1'b0;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || o_result.ready) begin
                    n_ov = 1'b1;
                    n_ocpx = r_use_mem ? r_rd_data : t_val'(0);
                    n_ooor = r_rej;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_fin <= t_addr'(1);
            r_limit <= '1;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_fin <= n_fin;
            r_ov <= n_ov;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        r_n <= n_n;
        r_m <= n_m;
        r_mn <= n_mn;
        r_bound <= n_bound;
        r_k <= n_k;
        r_prev <= n_prev;
        r_cur <= n_cur;
        r_a <= n_a;
        r_use_mem <= n_use_mem;
        r_rej <= n_rej;
        r_ocpx <= n_ocpx;
        r_ooor <= n_ooor;
    end

    a_fin_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_fin >= $past(r_fin)))
        else $error("finalized index moved backward");

    a_extend_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BND) |-> (r_n == r_fin + t_addr'(1)))
        else $error("extension index is not the next one");

    a_sum_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SB) |-> (r_m < r_n && r_m >= t_addr'(6)))
        else $error("sum term out of range");

    a_prod_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PC) |-> (r_mn > {1'b0, r_n} && !r_mn[ADDR_W]))
        else $error("product target not above current index");
endmodule
`default_nettype wire

// File: verif/ict_result_checker.sv
// Checker for the integer complexity table: watches the query, result and register
// ports, keeps its own copy of the table and compares each result with the prediction.
// Depends on ict_pkg and the handshake interfaces in ict_if.
`timescale 1ns / 1ps
`default_nettype none
module ict_result_checker import ict_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire t_addr i_cfg_wdata,
    ict_query_if      i_query,
    ict_result_if     i_result,
    output int        o_fail_count,
    output int        o_pending
);
    typedef struct packed {
        t_val complexity;
        logic out_of_range;
    } t_answer;

    t_val    cplx_mem [65536];
    int      done_upto;
    t_addr   lim_reg;
    t_answer answer_q [$];

    function automatic longint best_product(input int ones);
        longint r;
        r = 1;
        while (ones >= 5 || ones == 3) begin
            r = r * 3;
            if (r > (longint'(1) << 40)) begin
                r = longint'(1) << 40;
            end
            ones = ones - 3;
        end
        return r << (ones / 2);
    endfunction

    function automatic t_val clip_sum(input t_val a, input t_val b);
        int s;
        s = int'(a) + int'(b);
        return (s > 127) ? 7'd127 : t_val'(s);
    endfunction

    function automatic void grow_to(input int n);
        int     prev;
        int     k;
        longint lim;
        int     mn;
        t_val   v;
        v = clip_sum(cplx_mem[n-1], 7'd1);
        if (v < cplx_mem[n]) cplx_mem[n] = v;
        prev = int'(cplx_mem[n-1]);
        k = prev / 2;
        while (k > 0 && best_product(k) + best_product(prev - k) < longint'(n)) k--;
        lim = best_product(k);
        for (int m = 6; longint'(m) <= lim && m < n; m++) begin
            v = clip_sum(cplx_mem[m], cplx_mem[n-m]);
            if (v < cplx_mem[n]) cplx_mem[n] = v;
        end
        mn = 2 * n;
        for (int m = 2; m <= n && mn < 65536; m++) begin
            v = clip_sum(cplx_mem[m], cplx_mem[n]);
            if (v < cplx_mem[mn]) cplx_mem[mn] = v;
            mn = mn + n;
        end
    endfunction

    function automatic t_answer look_up(input t_addr q);
        t_answer a;
        if (q == 0 || q > lim_reg) begin
            a.complexity = '0;
            a.out_of_range = 1'b1;
        end else begin
            while (done_upto < int'(q)) begin
                done_upto++;
                grow_to(done_upto);
            end
            a.complexity = cplx_mem[q];
            a.out_of_range = 1'b0;
        end
        return a;
    endfunction

    assign o_pending = answer_q.size();

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            for (int i = 0; i < 65536; i++) cplx_mem[i] = VALUE_CAP;
            cplx_mem[1] = 7'd1;
            done_upto = 1;
            lim_reg = 16'hFFFF;
            answer_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) lim_reg = i_cfg_wdata;
            if (i_query.valid && i_query.ready) answer_q.push_back(look_up(i_query.query_index));
            if (i_result.valid && i_result.ready) begin
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result complexity=%0d out_of_range=%0b", $time,
                             i_result.complexity, i_result.out_of_range);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answer_q.pop_front();
                    if (want.complexity !== i_result.complexity ||
                        want.out_of_range !== i_result.out_of_range) begin
                        $display("%0t: expected complexity=%0d out_of_range=%0b, got %0d %0b",
                                 $time, want.complexity, want.out_of_range,
                                 i_result.complexity, i_result.out_of_range);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: verif/tb_integer_complexity_table_top.sv
// Testbench top for the integer complexity table: drives directed and random requests
// under several idle patterns and register settings, and gives the verdict.
// Depends on ict_pkg, ict_if, integer_complexity_table_top and ict_result_checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_integer_complexity_table_top;
    import ict_pkg::*;

    localparam int IDLE_LIMIT = 3000000;
    localparam int IN_RANGE_CAP = 8191;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  cfg_we = 1'b0;
    t_addr cfg_wdata = '0;
    int    fail_count;
    int    pending;
    int    send_idle_pct = 0;
    int    stall_pct = 0;
    int    quiet_cycles = 0;
    t_addr cur_limit = 16'hFFFF;

    ict_query_if  q_if ();
    ict_result_if r_if ();

    integer_complexity_table_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_query    (q_if),
        .o_result   (r_if)
    );

    ict_result_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_query     (q_if),
        .i_result    (r_if),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        q_if.valid = 1'b0;
        q_if.query_index = '0;
        r_if.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        r_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((q_if.valid && q_if.ready) || (r_if.valid && r_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input t_addr q);
        while ($urandom_range(99) < send_idle_pct) begin
            q_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        q_if.valid <= 1'b1;
        q_if.query_index <= q;
        do @(posedge i_clk); while (!q_if.ready);
    endtask

    task automatic set_limit(input t_addr v);
        q_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        cur_limit = v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic t_addr pick_query();
        t_addr q;
        case ($urandom_range(3))
            0: q = t_addr'($urandom);
            1: q = t_addr'($urandom_range(40));
            default: q = t_addr'($urandom_range(1, 1200));
        endcase
        if (q <= cur_limit && q > IN_RANGE_CAP) q = t_addr'(q % (IN_RANGE_CAP + 1));
        return q;
    endfunction

    initial begin
        t_addr directed [] = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd12,
                               16'd0, 16'd100, 16'd1, 16'd2000};
        t_addr limits [4] = '{16'hFFFF, 16'd300, 16'd5000, 16'd2};
        int    idles [4] = '{0, 78, 0, 8};
        int    stalls [4] = '{0, 0, 78, 8};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[i]) send_request(directed[i]);
        set_limit(16'd2);
        send_request(16'd2);
        send_request(16'd3);
        send_request(16'd1);
        send_request(16'd100);
        send_request(16'hFFFF);
        set_limit(16'd8191);
        send_request(16'd8191);
        set_limit(16'hFFFE);
        send_request(16'hFFFF);
        send_request(16'd8000);
        for (int p = 0; p < 4; p++) begin
            set_limit(limits[p]);
            send_idle_pct = idles[p];
            stall_pct = stalls[p];
            for (int i = 0; i < 30; i++) send_request(pick_query());
        end
        q_if.valid <= 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
